@@ rtl/radio_frame_rx_filter_power_control_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by rfrx_back.
// ----------------------------------------------------------------------------
`ifndef RADIO_FRAME_RX_FILTER_POWER_CONTROL_CORE_MACROS_SVH
`define RADIO_FRAME_RX_FILTER_POWER_CONTROL_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/rfrx_pkg.sv @@
// ----------------------------------------------------------------------------
// rfrx_pkg
// Types, codes and helpers for the receive frame filter and power control.
// ----------------------------------------------------------------------------
package rfrx_pkg;

    localparam logic [7:0] FRAME_LIMIT  = 8'd66;
    localparam logic [4:0] MAX_LEVEL    = 5'd31;
    localparam logic [4:0] RESET_LEVEL  = 5'd20;
    localparam logic [5:0] MAX_PAYLOAD  = 6'd63;
    localparam logic [7:0] HEADER_BYTES = 8'd3;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPY_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RSSI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP  = 3'd4;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_REJECT  = 3'd1,
        KIND_ACKRSSI = 3'd2,
        KIND_DATA    = 3'd3,
        KIND_TIMEOUT = 3'd4
    } kind_t;

    // one queue entry: what the parser decided, plus the frame context
    typedef struct packed {
        kind_t       kind;
        logic [9:0]  sender;
        logic [9:0]  target;
        logic [5:0]  remaining;
        logic [2:0]  flags;     // ack received, ack requested, rssi requested
        logic [7:0]  data;      // payload byte, or raw rssi byte for KIND_ACKRSSI
        logic        last;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  sender;
        logic [9:0]  target;
        logic [5:0]  remaining;
        logic [2:0]  flags;
        logic [8:0]  rssi_dbm;
        logic [7:0]  data;
        logic [4:0]  level;
        logic        last;
    } result_t;

    function automatic logic [4:0] raise_level(input logic [4:0] level,
                                               input logic [4:0] step);
        logic [5:0] sum;
        sum = {1'b0, level} + {1'b0, step};
        if (level == MAX_LEVEL) begin
            return level;
        end
        return (sum > {1'b0, MAX_LEVEL}) ? MAX_LEVEL : sum[4:0];
    endfunction

endpackage

@@ rtl/rfrx_front.sv @@
// ----------------------------------------------------------------------------
// rfrx_front
// Header parser and address filter; turns control, rssi and payload bytes and ack timeouts into queue entries.
// ----------------------------------------------------------------------------
module rfrx_front
    import rfrx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take,
    input  logic        operation,
    input  logic        frame_start,
    input  logic [7:0]  rx_byte,
    input  logic [9:0]  node_address,
    input  logic [9:0]  broadcast_address,
    input  logic        spy_mode,
    output logic        push,
    output entry_t      entry
);

    typedef enum logic [5:0] {
        POS_IDLE    = 6'b000001,
        POS_TARGET  = 6'b000010,
        POS_SENDER  = 6'b000100,
        POS_CONTROL = 6'b001000,
        POS_RSSI    = 6'b010000,
        POS_DATA    = 6'b100000
    } pos_t;

    pos_t       pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [9:0] target_reg, target_next;
    logic [9:0] sender_reg, sender_next;
    logic [5:0] rem_reg, rem_next;
    logic [2:0] flags_reg, flags_next;

    logic       match;
    logic [7:0] len_less;
    logic [5:0] count;
    logic [9:0] tgt_full;
    logic [9:0] snd_full;
    logic [5:0] rem_dec;

    assign tgt_full = {rx_byte[3:2], target_reg[7:0]};
    assign snd_full = {rx_byte[1:0], sender_reg[7:0]};
    assign match    = spy_mode || (tgt_full == node_address) ||
                      (tgt_full == broadcast_address);
    assign len_less = len_reg - HEADER_BYTES;
    assign count    = (len_less > {2'b00, MAX_PAYLOAD}) ? MAX_PAYLOAD : len_less[5:0];
    assign rem_dec  = (rem_reg != 6'd0) ? rem_reg - 6'd1 : rem_reg;

    always_comb begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        target_next = target_reg;
        sender_next = sender_reg;
        rem_next    = rem_reg;
        flags_next  = flags_reg;
        push        = 1'b0;
        entry.kind  = KIND_TIMEOUT;
        entry.data  = 8'd0;
        entry.last  = 1'b0;

        if (take) begin
            if (operation) begin
                push = 1'b1;
            end else if (frame_start) begin
                len_next    = (rx_byte > FRAME_LIMIT) ? FRAME_LIMIT : rx_byte;
                target_next = 10'd0;
                sender_next = 10'd0;
                rem_next    = 6'd0;
                flags_next  = 3'd0;
                pos_next    = POS_TARGET;
            end else begin
                unique case (pos_reg)
                    POS_IDLE: begin
                    end
                    POS_TARGET: begin
                        target_next = {2'b00, rx_byte};
                        pos_next    = POS_SENDER;
                    end
                    POS_SENDER: begin
                        sender_next = {2'b00, rx_byte};
                        pos_next    = POS_CONTROL;
                    end
                    POS_CONTROL: begin
                        target_next = tgt_full;
                        sender_next = snd_full;
                        push        = 1'b1;
                        if (!match || len_reg < HEADER_BYTES) begin
                            rem_next   = 6'd0;
                            flags_next = 3'd0;
                            entry.kind = KIND_REJECT;
                            entry.last = 1'b1;
                            pos_next   = POS_IDLE;
                        end else begin
                            flags_next = rx_byte[7:5];
                            entry.kind = KIND_HEADER;
                            if (rx_byte[7] && count != 6'd0) begin
                                rem_next = count - 6'd1;
                                pos_next = POS_RSSI;
                            end else begin
                                rem_next   = count;
                                entry.last = (count == 6'd0);
                                pos_next   = (count == 6'd0) ? POS_IDLE : POS_DATA;
                            end
                        end
                    end
                    POS_RSSI: begin
                        push       = 1'b1;
                        entry.kind = KIND_ACKRSSI;
                        entry.data = rx_byte;
                        entry.last = (rem_reg == 6'd0);
                        pos_next   = (rem_reg == 6'd0) ? POS_IDLE : POS_DATA;
                    end
                    POS_DATA: begin
                        push       = 1'b1;
                        rem_next   = rem_dec;
                        entry.kind = KIND_DATA;
                        entry.data = rx_byte;
                        entry.last = (rem_dec == 6'd0);
                        if (rem_dec == 6'd0) begin
                            pos_next = POS_IDLE;
                        end
                    end
                    default: pos_next = POS_IDLE;
                endcase
            end
        end

        entry.sender    = sender_next;
        entry.target    = target_next;
        entry.remaining = rem_next;
        entry.flags     = flags_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_IDLE;
            len_reg    <= 8'd0;
            target_reg <= 10'd0;
            sender_reg <= 10'd0;
            rem_reg    <= 6'd0;
            flags_reg  <= 3'd0;
        end else begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            target_reg <= target_next;
            sender_reg <= sender_next;
            rem_reg    <= rem_next;
            flags_reg  <= flags_next;
        end
    end

endmodule

@@ rtl/rfrx_queue.sv @@
// ----------------------------------------------------------------------------
// rfrx_queue
// Short register queue between the parser and the power control stage.
// ----------------------------------------------------------------------------
module rfrx_queue
    import rfrx_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_entry
);

    entry_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_entry = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/rfrx_back.sv @@
// ----------------------------------------------------------------------------
// rfrx_back
// Transmit level tracking, ack RSSI capture and the output register.
// ----------------------------------------------------------------------------
`include "radio_frame_rx_filter_power_control_core_macros.svh"

module rfrx_back
    import rfrx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  entry_t      in_entry,
    input  logic [8:0]  target_rssi,
    input  logic [4:0]  level_step,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);

    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;
    logic [4:0]  level_reg, level_next;
    logic [8:0]  rssi_reg, rssi_next;
    logic        take;
    logic [8:0]  rssi_new;
    logic        regulate;
    logic        shows_reject;
    logic        shows_timeout;
    logic        reject_clean;
    logic        can_raise;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    assign rssi_new  = 9'd0 - {1'b0, in_entry.data};
    assign regulate  = (target_rssi != 9'd0);

    always_comb begin
        level_next = level_reg;
        rssi_next  = rssi_reg;
        if (take) begin
            case (in_entry.kind)
                KIND_TIMEOUT: level_next = raise_level(level_reg, level_step);
                KIND_ACKRSSI: begin
                    rssi_next = rssi_new;
                    if (regulate) begin
                        if ($signed(rssi_new) < $signed(target_rssi)) begin
                            level_next = raise_level(level_reg, level_step);
                        end else if ($signed(rssi_new) > $signed(target_rssi) &&
                                     level_reg != 5'd0) begin
                            level_next = level_reg - 5'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res_next           = res_reg;
        out_valid_next     = out_valid_reg;
        if (take) begin
            out_valid_next     = 1'b1;
            res_next.kind      = in_entry.kind;
            res_next.sender    = in_entry.sender;
            res_next.target    = in_entry.target;
            res_next.remaining = in_entry.remaining;
            res_next.flags     = in_entry.flags;
            res_next.rssi_dbm  = rssi_next;
            res_next.data      = (in_entry.kind == KIND_DATA) ? in_entry.data : 8'd0;
            res_next.level     = level_next;
            res_next.last      = in_entry.last;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            level_reg     <= RESET_LEVEL;
            rssi_reg      <= 9'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            level_reg     <= level_next;
            rssi_reg      <= rssi_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign shows_reject  = out_valid_reg && (res_reg.kind == KIND_REJECT);
    assign shows_timeout = out_valid_reg && (res_reg.kind == KIND_TIMEOUT);
    assign reject_clean  = res_reg.last && (res_reg.flags == 3'd0) &&
                           (res_reg.remaining == 6'd0);
    assign can_raise     = take && (in_entry.kind == KIND_TIMEOUT) &&
                           (level_reg != MAX_LEVEL) && (level_step != 5'd0);

    `ASSERT_IMPL(a_reject_closes, aclk, aresetn, shows_reject, reject_clean)
    `ASSERT_IMPL(a_timeout_open, aclk, aresetn, shows_timeout, !res_reg.last)
    `ASSERT_NEXT(a_timeout_raises, aclk, aresetn, can_raise, level_reg > $past(level_reg))
    `ASSERT_IMPL(a_level_shown, aclk, aresetn, shows_timeout, res_reg.level == level_reg)

endmodule

@@ rtl/radio_frame_rx_filter_power_control_core.sv @@
// ----------------------------------------------------------------------------
// radio_frame_rx_filter_power_control_core
// Receive frame filter with automatic transmit power control.
// ----------------------------------------------------------------------------
// Takes one received byte or ack-timeout event per cycle, sustained, and
// gives at most one result per item: the parser registers
// its decision into a two-entry queue, and the power control stage registers
// the result. Back-pressure on the result side fills the queue before
// s_tready drops. No clearing pass after reset; configuration writes take
// effect the cycle after they are accepted and are always ready.
module radio_frame_rx_filter_power_control_core
    import rfrx_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic [1:0]            s_tuser,   // [0] operation, [1] frame_start

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [9:0] sender_id, [19:10] target_id, [25:20] data_length,
    // [26] ack flag, [27] ack request, [28] rssi request,
    // [37:29] ack rssi, [45:38] data_byte, [50:46] transmit_level, [55:51] zero
    output logic [55:0]           m_tdata,
    output logic [2:0]            m_tuser,   // [2:0] kind
    output logic                  m_tlast,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [9:0] node_addr_reg;
    logic [9:0] bcast_addr_reg;
    logic       spy_reg;
    logic [8:0] trssi_reg;
    logic [4:0] step_reg;

    logic       q_full;
    logic       push;
    entry_t     push_entry;
    logic       q_valid;
    logic       q_ready;
    entry_t     q_entry;
    result_t    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_addr_reg  <= 10'd0;
            bcast_addr_reg <= 10'd255;
            spy_reg        <= 1'b0;
            trssi_reg      <= 9'd0;
            step_reg       <= 5'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NODE_ADDR:   node_addr_reg  <= cfg_data;
                CFG_BCAST_ADDR:  bcast_addr_reg <= cfg_data;
                CFG_SPY_MODE:    spy_reg        <= cfg_data[0];
                CFG_TARGET_RSSI: trssi_reg      <= cfg_data[8:0];
                CFG_LEVEL_STEP:  step_reg       <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !q_full;

    rfrx_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .take              (s_tvalid && s_tready),
        .operation         (s_tuser[0]),
        .frame_start       (s_tuser[1]),
        .rx_byte           (s_tdata),
        .node_address      (node_addr_reg),
        .broadcast_address (bcast_addr_reg),
        .spy_mode          (spy_reg),
        .push              (push),
        .entry             (push_entry)
    );

    rfrx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_entry  (q_entry)
    );

    rfrx_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_entry    (q_entry),
        .target_rssi (trssi_reg),
        .level_step  (step_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res)
    );

    assign m_tdata = {5'd0, res.level, res.data, res.rssi_dbm, res.flags[0],
                      res.flags[1], res.flags[2], res.remaining, res.target, res.sender};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

@@ verif/rfrx_result_checker.sv @@
// ----------------------------------------------------------------------------
// rfrx_result_checker
// Watches the byte, result and register channels of the frame filter, keeps
// its own copy of the parser and power control state, and compares every
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module rfrx_result_checker
    import rfrx_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [55:0]           m_tdata,
    input  logic [2:0]            m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        AT_IDLE,
        AT_TARGET,
        AT_SENDER,
        AT_CONTROL,
        AT_RSSI,
        AT_DATA
    } parse_pos_t;

    // register copies
    logic [9:0]        node_addr;
    logic [9:0]        bcast_addr;
    logic              spy_on;
    logic signed [8:0] rssi_goal;
    logic [4:0]        level_step;

    // parser and power control copies
    parse_pos_t        pos;
    logic [7:0]        frame_len;
    logic [9:0]        tgt_addr;
    logic [9:0]        snd_addr;
    logic [5:0]        payload_left;
    logic              dropping;
    logic [4:0]        tx_level;
    logic signed [8:0] rx_rssi;
    logic [2:0]        ctrl_flags;   // ack received, ack requested, rssi requested

    result_t expected_results[$];
    int      result_count = 0;

    function automatic void restore_defaults();
        node_addr    = '0;
        bcast_addr   = 10'd255;
        spy_on       = 1'b0;
        rssi_goal    = '0;
        level_step   = 5'd1;
        pos          = AT_IDLE;
        frame_len    = '0;
        tgt_addr     = '0;
        snd_addr     = '0;
        payload_left = '0;
        dropping     = 1'b1;
        tx_level     = RESET_LEVEL;
        rx_rssi      = '0;
        ctrl_flags   = '0;
    endfunction

    function automatic result_t snapshot(input kind_t k, input logic [7:0] d, input logic last);
        result_t r;
        r.kind      = k;
        r.sender    = snd_addr;
        r.target    = tgt_addr;
        r.remaining = payload_left;
        r.flags     = ctrl_flags;
        r.rssi_dbm  = rx_rssi;
        r.data      = d;
        r.level     = tx_level;
        r.last      = last;
        return r;
    endfunction

    function automatic void raise_tx_level();
        if (tx_level != MAX_LEVEL)
            tx_level = ({1'b0, tx_level} + level_step > MAX_LEVEL) ? MAX_LEVEL
                                                                   : tx_level + level_step;
    endfunction

    function automatic void close_frame();
        dropping = 1'b1;
        pos      = AT_IDLE;
    endfunction

    task automatic advance_parser(input logic is_timeout, input logic [7:0] b,
                                  input logic start);
        logic [7:0] count;
        if (is_timeout) begin
            raise_tx_level();
            expected_results.push_back(snapshot(KIND_TIMEOUT, 8'd0, 1'b0));
            return;
        end
        if (start) begin
            frame_len    = (b > FRAME_LIMIT) ? FRAME_LIMIT : b;
            tgt_addr     = '0;
            snd_addr     = '0;
            payload_left = '0;
            ctrl_flags   = '0;
            dropping     = 1'b0;
            pos          = AT_TARGET;
            return;
        end
        if (dropping)
            return;
        case (pos)
            AT_TARGET: begin
                tgt_addr = {2'b00, b};
                pos      = AT_SENDER;
            end
            AT_SENDER: begin
                snd_addr = {2'b00, b};
                pos      = AT_CONTROL;
            end
            AT_CONTROL: begin
                tgt_addr[9:8] = b[3:2];
                snd_addr[9:8] = b[1:0];
                if (!(spy_on || tgt_addr == node_addr || tgt_addr == bcast_addr) ||
                    frame_len < HEADER_BYTES) begin
                    payload_left = '0;
                    ctrl_flags   = '0;
                    expected_results.push_back(snapshot(KIND_REJECT, 8'd0, 1'b1));
                    close_frame();
                end else begin
                    count = frame_len - HEADER_BYTES;
                    if (count > MAX_PAYLOAD)
                        count = MAX_PAYLOAD;
                    ctrl_flags = b[7:5];
                    if (b[7] && count != 0) begin
                        // ack carries its rssi byte ahead of the payload
                        payload_left = 6'(count - 1);
                        pos          = AT_RSSI;
                        expected_results.push_back(snapshot(KIND_HEADER, 8'd0, 1'b0));
                    end else begin
                        payload_left = count[5:0];
                        if (count == 0) begin
                            expected_results.push_back(snapshot(KIND_HEADER, 8'd0, 1'b1));
                            close_frame();
                        end else begin
                            pos = AT_DATA;
                            expected_results.push_back(snapshot(KIND_HEADER, 8'd0, 1'b0));
                        end
                    end
                end
            end
            AT_RSSI: begin
                rx_rssi = 9'd0 - {1'b0, b};
                if (rssi_goal != 0) begin
                    if (rx_rssi < rssi_goal && tx_level != MAX_LEVEL)
                        raise_tx_level();
                    else if (rx_rssi > rssi_goal && tx_level != 0)
                        tx_level = tx_level - 1'b1;
                end
                if (payload_left == 0) begin
                    expected_results.push_back(snapshot(KIND_ACKRSSI, 8'd0, 1'b1));
                    close_frame();
                end else begin
                    pos = AT_DATA;
                    expected_results.push_back(snapshot(KIND_ACKRSSI, 8'd0, 1'b0));
                end
            end
            AT_DATA: begin
                if (payload_left != 0)
                    payload_left = payload_left - 1'b1;
                expected_results.push_back(snapshot(KIND_DATA, b, payload_left == 0));
                if (payload_left == 0)
                    close_frame();
            end
            default: close_frame();
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      result_count, what, got, want));
    endtask

    always @(posedge aclk) begin : watch
        result_t want_res;
        if (!aresetn) begin
            restore_defaults();
            expected_results.delete();
            errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d (kind %0d) with nothing expected",
                                              result_count, m_tuser));
                end else begin
                    want_res = expected_results.pop_front();
                    compare_field("kind",           m_tuser,        want_res.kind);
                    compare_field("sender_id",      m_tdata[9:0],   want_res.sender);
                    compare_field("target_id",      m_tdata[19:10], want_res.target);
                    compare_field("data_length",    m_tdata[25:20], want_res.remaining);
                    compare_field("ack flag",       m_tdata[26],    want_res.flags[2]);
                    compare_field("ack request",    m_tdata[27],    want_res.flags[1]);
                    compare_field("rssi request",   m_tdata[28],    want_res.flags[0]);
                    compare_field("ack rssi",       m_tdata[37:29], want_res.rssi_dbm);
                    compare_field("data_byte",      m_tdata[45:38], want_res.data);
                    compare_field("transmit_level", m_tdata[50:46], want_res.level);
                    compare_field("last",           m_tlast,        want_res.last);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NODE_ADDR:   node_addr  = cfg_data[9:0];
                    CFG_BCAST_ADDR:  bcast_addr = cfg_data[9:0];
                    CFG_SPY_MODE:    spy_on     = cfg_data[0];
                    CFG_TARGET_RSSI: rssi_goal  = cfg_data[8:0];
                    CFG_LEVEL_STEP:  level_step = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                advance_parser(s_tuser[0], s_tdata, s_tuser[1]);
        end
        outstanding <= expected_results.size();
    end

endmodule

@@ verif/tb_radio_frame_rx_filter_power_control_core.sv @@
// ----------------------------------------------------------------------------
// tb_radio_frame_rx_filter_power_control_core
// Feeds received frames and ack timeouts into the frame filter under several
// register settings, with random gaps and output stalls; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_radio_frame_rx_filter_power_control_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rfrx_pkg::*;

    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_TIMEOUT  = 1'b1;
    localparam int   IDLE_LIMIT  = 2000;
    localparam int   PHASE_ITEMS = 120;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int         errors;
    int         outstanding;
    int         items_sent  = 0;
    int         idle_cycles = 0;
    logic       calm        = 1'b0;    // no gaps or stalls while set
    logic [9:0] cur_node    = 10'd0;
    logic [9:0] cur_bcast   = 10'd255;

    radio_frame_rx_filter_power_control_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rfrx_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 25);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // valid stays high from one item to the next unless a gap is drawn
    task automatic send_item(input logic op, input logic [7:0] b, input logic start);
        while (!calm && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {start, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_timeout();
        send_item(OP_TIMEOUT, 8'($urandom), 1'($urandom));
        items_sent++;
    endtask

    task automatic frame_byte(input logic [7:0] b);
        if ($urandom_range(99) < 3)
            send_timeout();
        send_item(OP_BYTE, b, 1'b0);
        items_sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [9:0] tgt,
                              input logic [9:0] snd, input logic [2:0] flags,
                              input int n_bytes);
        send_item(OP_BYTE, len, 1'b1);
        items_sent++;
        frame_byte(tgt[7:0]);
        frame_byte(snd[7:0]);
        frame_byte({flags, 1'($urandom), tgt[9:8], snd[9:8]});
        repeat (n_bytes) frame_byte(8'($urandom));
    endtask

    task automatic random_frame();
        int         r;
        int         need;
        int         n_bytes;
        logic [7:0] len;
        logic [9:0] tgt;
        logic [2:0] flags;
        r = $urandom_range(99);
        if (r < 72)      len = 8'($urandom_range(12, 3));
        else if (r < 82) len = 8'($urandom_range(2, 0));
        else if (r < 94) len = 8'($urandom_range(66, 13));
        else             len = 8'($urandom_range(255, 67));
        r = $urandom_range(99);
        if (r < 40)      tgt = cur_node;
        else if (r < 65) tgt = cur_bcast;
        else             tgt = 10'($urandom);
        flags    = 3'($urandom);
        flags[2] = ($urandom_range(99) < 60);
        need = ((len > FRAME_LIMIT) ? int'(FRAME_LIMIT) : int'(len)) - int'(HEADER_BYTES);
        if (need < 0)
            need = 0;
        // mostly complete frames; some cut short or followed by stray bytes
        n_bytes = ($urandom_range(99) < 85) ? need : $urandom_range(need + 3, 0);
        send_frame(len, tgt, 10'($urandom), flags, n_bytes);
    endtask

    task automatic random_phase(input int count);
        int stop;
        int r;
        stop = items_sent + count;
        while (items_sent < stop) begin
            r = $urandom_range(99);
            if (r < 6)
                send_timeout();
            else if (r < 10)
                send_item(OP_BYTE, 8'($urandom), 1'b0);
            else
                random_frame();
        end
    endtask

    task automatic configure(input logic [9:0] node, input logic [9:0] bcast,
                             input logic spy, input logic [8:0] goal,
                             input logic [4:0] step);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]  idx  [5];
        idx  = '{CFG_NODE_ADDR, CFG_BCAST_ADDR, CFG_SPY_MODE, CFG_TARGET_RSSI,
                 CFG_LEVEL_STEP};
        // unused upper bits carry junk
        vals = '{node, bcast, {9'($urandom), spy}, {1'($urandom), goal},
                 {5'($urandom), step}};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cur_node  = node;
        cur_bcast = bcast;
    endtask

    // hold the sender until every result is back, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(OP_BYTE, 8'hA5, 1'b0);             // stray byte before any frame
        send_timeout();
        send_frame(8'd5, 10'd255, 10'h3FF, 3'b000, 2);
        send_frame(8'd0, 10'd0, 10'd0, 3'b111, 0);    // too short, rejected
        send_frame(8'd4, 10'd0, 10'd1, 3'b100, 1);    // ack with rssi only
        send_item(OP_BYTE, 8'd9, 1'b1);               // abandoned by the next start
        frame_byte(8'd0);
        send_frame(8'd3, 10'd0, 10'd5, 3'b010, 0);    // header ends the frame
        send_frame(8'd255, 10'h3FF, 10'd0, 3'b111, 0);
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: configure(10'h3FF, 10'd0, 1'b0, 9'h101, 5'd31);
                1: configure(10'($urandom), 10'($urandom), 1'b1, 9'h101, 5'd0);
                2: configure(10'($urandom), 10'h3FF, 1'b0, 9'h0FF, 5'($urandom));
                3: configure(10'd0, 10'd255, 1'b0, 9'd0, 5'd1);
                4: configure(10'($urandom), 10'($urandom), 1'($urandom), 9'h1C4,
                             5'($urandom));
                default: configure(10'($urandom), 10'($urandom), 1'($urandom), 9'h100,
                                   5'($urandom));
            endcase
            calm <= (p == 2);
            // spy mode with no step: drive the level down to zero with acks
            if (p == 1)
                repeat (34) send_frame(8'd4, 10'($urandom), 10'($urandom),
                                       {1'b1, 2'($urandom)}, 1);
            random_phase(PHASE_ITEMS);
            settle();
        end

        repeat (8) @(posedge aclk);
        if (errors == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
